// ===== rtl/sbsm_pkg.sv =====
`timescale 1ns / 1ps
package sbsm_pkg;

  localparam int unsigned WORK_RAM_DEPTH_DEF = 8192;
  localparam int unsigned MID_DEPTH_DEF      = 4;
  localparam int unsigned OUT_DEPTH_DEF      = 4;

  localparam logic [4:0] CTRL_RESET     = 5'h1C;
  localparam logic [4:0] PRG_CNT_RESET  = 5'd16;
  localparam logic [4:0] CHR_CNT_RESET  = 5'd0;
  localparam logic [2:0] SHIFT_LAST     = 3'd4;

  // config register index (paddr bit 2)
  localparam logic REG_PRG_COUNT = 1'b0;
  localparam logic REG_CHR_COUNT = 1'b1;

  // bus command on cmd_i
  typedef enum logic [1:0] {
    CMD_CPU_RD,
    CMD_CPU_WR,
    CMD_PPU_RD,
    CMD_PPU_WR
  } cmd_e;

  // classified access
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RAM_RD,
    OP_RAM_WR,
    OP_PRG_RD,
    OP_REG_WR,
    OP_PPU_RD,
    OP_PPU_WR
  } op_e;

  // load register target, addr bits 14:13
  typedef enum logic [1:0] {
    TGT_CTRL,
    TGT_CHR_LOW,
    TGT_CHR_HIGH,
    TGT_PRG
  } tgt_e;

  // PRG mode, control bits 3:2
  typedef enum logic [1:0] {
    PRG_32K_A,
    PRG_32K_B,
    PRG_FIX_FIRST,
    PRG_FIX_LAST
  } prg_mode_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic        handled;
    logic        ram_hit;
    logic [17:0] xlat_addr;
    logic [7:0]  read_data;
    logic [1:0]  mirroring;
  } res_t;

  typedef struct packed {
    logic       en;
    logic       idx;
    logic [4:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [4:0] prg_cnt;
    logic [4:0] chr_cnt;
  } cfg_rd_t;

endpackage

// ===== rtl/sbsm_fifo.sv =====
`timescale 1ns / 1ps
module sbsm_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter type         T     = logic,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  T              din_i,
  output logic          full_o,
  input  logic          pop_i,
  output T              dout_o,
  output logic          empty_o,
  output logic [CW-1:0] count_o
);

  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ===== rtl/sbsm_front.sv =====
`timescale 1ns / 1ps
module sbsm_front
  import sbsm_pkg::*;
(
  input  logic [1:0]  cmd_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  write_data_i,
  output item_t       item_o
);

  logic in_ram, in_rom, in_chr;

  assign in_ram = (addr_i[15:13] == 3'b011);
  assign in_rom = addr_i[15];
  assign in_chr = (addr_i[15:13] == 3'b000);

  always_comb begin
    item_o.addr = addr_i;
    item_o.data = write_data_i;
    item_o.op   = OP_NONE;
    case (cmd_e'(cmd_i))
      CMD_CPU_RD: begin
        if (in_ram) item_o.op = OP_RAM_RD;
        else if (in_rom) item_o.op = OP_PRG_RD;
      end
      CMD_CPU_WR: begin
        if (in_ram) item_o.op = OP_RAM_WR;
        else if (in_rom) item_o.op = OP_REG_WR;
      end
      CMD_PPU_RD: begin
        if (in_chr) item_o.op = OP_PPU_RD;
      end
      default: begin
        if (in_chr) item_o.op = OP_PPU_WR;
      end
    endcase
  end

endmodule

// ===== rtl/sbsm_back.sv =====
`timescale 1ns / 1ps
module sbsm_back
  import sbsm_pkg::*;
#(
  parameter int unsigned WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF,
  localparam int unsigned RAM_AW        = $clog2(WORK_RAM_DEPTH)
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_wr_i,
  output cfg_rd_t cfg_rd_o,
  input  logic    item_valid_i,
  input  item_t   item_i,
  input  logic    space_i,
  output logic    item_pop_o,
  output logic    res_valid_o,
  output res_t    res_o
);

  // bank state
  logic [4:0] shift_q, shift_d;
  logic [2:0] scnt_q, scnt_d;
  logic [4:0] ctrl_q, ctrl_d;
  logic [4:0] chr_whole_q, chr_whole_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [2:0] prg_whole_q, prg_whole_d;
  logic [3:0] prg_low_q, prg_low_d;
  logic [3:0] prg_high_q, prg_high_d;
  logic [4:0] prg_cnt_q, prg_cnt_d;
  logic [4:0] chr_cnt_q, chr_cnt_d;

  // writeback stage
  logic       w_valid_q;
  logic       w_ram_rd_q;
  res_t       w_res_q;
  res_t       e_res;
  logic       e_ram_rd;

  logic [7:0] ram_q;
  logic [7:0] mem [WORK_RAM_DEPTH];
  logic [RAM_AW-1:0] ram_idx;

  logic [4:0] load_val;
  logic [3:0] bank4;
  logic [4:0] bank5;
  logic [4:0] prg_cnt_m1;
  logic       issue;

  assign issue      = item_valid_i && space_i;
  assign item_pop_o = issue;
  assign ram_idx    = item_i.addr[RAM_AW-1:0];
  assign load_val   = {item_i.data[0], shift_q[4:1]};
  assign cfg_rd_o   = '{prg_cnt: prg_cnt_q, chr_cnt: chr_cnt_q};

  always_comb begin
    shift_d     = shift_q;
    scnt_d      = scnt_q;
    ctrl_d      = ctrl_q;
    chr_whole_d = chr_whole_q;
    chr_low_d   = chr_low_q;
    chr_high_d  = chr_high_q;
    prg_whole_d = prg_whole_q;
    prg_low_d   = prg_low_q;
    prg_high_d  = prg_high_q;
    prg_cnt_d   = prg_cnt_q;
    chr_cnt_d   = chr_cnt_q;
    prg_cnt_m1  = prg_cnt_q - 5'd1;
    e_ram_rd    = 1'b0;
    bank4       = '0;
    bank5       = '0;
    e_res       = '0;

    if (cfg_wr_i.en) begin
      unique case (cfg_wr_i.idx)
        REG_PRG_COUNT: begin
          prg_cnt_d  = cfg_wr_i.data;
          prg_high_d = 4'(cfg_wr_i.data - 5'd1);
        end
        default: chr_cnt_d = cfg_wr_i.data;
      endcase
    end

    if (issue) begin
      case (item_i.op) inside
        OP_RAM_RD: begin
          e_res.handled = 1'b1;
          e_res.ram_hit = 1'b1;
          e_ram_rd      = 1'b1;
        end
        OP_RAM_WR: begin
          e_res.handled = 1'b1;
          e_res.ram_hit = 1'b1;
        end
        OP_PRG_RD: begin
          e_res.handled = 1'b1;
          if (ctrl_q[3]) begin
            bank4 = item_i.addr[14] ? prg_high_q : prg_low_q;
            e_res.xlat_addr = {bank4, item_i.addr[13:0]};
          end else begin
            e_res.xlat_addr = {prg_whole_q, item_i.addr[14:0]};
          end
        end
        OP_REG_WR: begin
          if (item_i.data[7]) begin
            // reset write: clear load register, force 16K mode, last fixed
            shift_d = '0;
            scnt_d  = '0;
            ctrl_d  = ctrl_q | 5'h0C;
          end else if (scnt_q == SHIFT_LAST) begin
            shift_d = '0;
            scnt_d  = '0;
            unique case (tgt_e'(item_i.addr[14:13]))
              TGT_CTRL: ctrl_d = load_val;
              TGT_CHR_LOW: begin
                if (ctrl_q[4]) chr_low_d = load_val;
                else chr_whole_d = {load_val[4:1], 1'b0};
              end
              TGT_CHR_HIGH: begin
                if (ctrl_q[4]) chr_high_d = load_val;
              end
              default: begin
                unique case (prg_mode_e'(ctrl_q[3:2])) inside
                  PRG_32K_A, PRG_32K_B: prg_whole_d = load_val[3:1];
                  PRG_FIX_FIRST: begin
                    prg_low_d  = '0;
                    prg_high_d = load_val[3:0];
                  end
                  default: begin
                    prg_high_d = prg_cnt_m1[3:0];
                    prg_low_d  = load_val[3:0];
                  end
                endcase
              end
            endcase
          end else begin
            shift_d = load_val;
            scnt_d  = scnt_q + 3'd1;
          end
        end
        OP_PPU_RD, OP_PPU_WR: begin
          if (chr_cnt_q == '0) begin
            // pattern RAM: straight through
            e_res.handled   = 1'b1;
            e_res.xlat_addr = {5'd0, item_i.addr[12:0]};
          end else if (item_i.op == OP_PPU_RD) begin
            e_res.handled = 1'b1;
            if (ctrl_q[4]) begin
              bank5 = item_i.addr[12] ? chr_high_q : chr_low_q;
              e_res.xlat_addr = {1'b0, bank5, item_i.addr[11:0]};
            end else begin
              e_res.xlat_addr = {1'b0, chr_whole_q[4:1], item_i.addr[12:0]};
            end
          end
        end
        default: ;
      endcase
    end
    e_res.mirroring = ctrl_d[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      scnt_q      <= '0;
      ctrl_q      <= CTRL_RESET;
      chr_whole_q <= '0;
      chr_low_q   <= '0;
      chr_high_q  <= '0;
      prg_whole_q <= '0;
      prg_low_q   <= '0;
      prg_high_q  <= 4'(PRG_CNT_RESET - 5'd1);
      prg_cnt_q   <= PRG_CNT_RESET;
      chr_cnt_q   <= CHR_CNT_RESET;
      w_valid_q   <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      scnt_q      <= scnt_d;
      ctrl_q      <= ctrl_d;
      chr_whole_q <= chr_whole_d;
      chr_low_q   <= chr_low_d;
      chr_high_q  <= chr_high_d;
      prg_whole_q <= prg_whole_d;
      prg_low_q   <= prg_low_d;
      prg_high_q  <= prg_high_d;
      prg_cnt_q   <= prg_cnt_d;
      chr_cnt_q   <= chr_cnt_d;
      w_valid_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      w_res_q    <= e_res;
      w_ram_rd_q <= e_ram_rd;
    end
  end

  // work RAM, registered read
  always_ff @(posedge clk_i) begin
    if (issue && item_i.op == OP_RAM_WR) begin
      mem[ram_idx] <= item_i.data;
    end
    if (issue && item_i.op == OP_RAM_RD) begin
      ram_q <= mem[ram_idx];
    end
  end

  always_comb begin
    res_o = w_res_q;
    res_o.read_data = w_ram_rd_q ? ram_q : 8'd0;
  end
  assign res_valid_o = w_valid_q;

endmodule

// ===== rtl/serial_bank_switch_mapper_top.sv =====
`timescale 1ns / 1ps
// Serial bank-switch cartridge mapper. Bus accesses enter through a queue
// port (push/full) and each one produces exactly one result transaction on
// the output queue port (empty/pop), in order. CPU writes to 0x8000-0xFFFF
// shift data bit 0 into a five-bit load register; the fifth write lands in
// the control, CHR-low, CHR-high or PRG register chosen by address bits
// 14:13, and a write with bit 7 set restarts the load and forces 16K PRG mode.
// 0x6000-0x7FFF is an internal 8K work RAM (contents undefined until written,
// no clearing after reset). Throughput is one access per clock while the
// output queue has room: the execute unit resolves an access against the
// bank registers and the single-port work RAM. An accepted access passes
// from the access queue through execute into the writeback register, then
// into the output queue, where its result can be popped.
// Configuration: APB, prg_bank_count at 0x0, chr_bank_count at 0x4; write
// only while the mapper is idle.
module serial_bank_switch_mapper_top
  import sbsm_pkg::*;
#(
  parameter int unsigned WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF,
  parameter int unsigned MID_DEPTH      = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH      = OUT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access queue
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  write_data_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic        handled_o,
  output logic        ram_hit_o,
  output logic [17:0] xlat_addr_o,
  output logic [7:0]  read_data_o,
  output logic [1:0]  mirroring_o,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned OSW = $clog2(OUT_DEPTH + 2);

  item_t          front_item;
  item_t          mid_item;
  logic           mid_empty;
  logic           back_pop;
  logic           back_valid;
  res_t           back_res;
  res_t           out_res;
  logic [OCW-1:0] out_count;
  logic           space;
  cfg_wr_t        cfg_wr;
  cfg_rd_t        cfg_rd;

  // front: classify the access on the way in
  sbsm_front u_front (
    .cmd_i        (cmd_i),
    .addr_i       (addr_i),
    .write_data_i (write_data_i),
    .item_o       (front_item)
  );

  // decoupling queue between classify and execute
  sbsm_fifo #(
    .DEPTH (MID_DEPTH),
    .T     (item_t)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_item),
    .full_o  (full),
    .pop_i   (back_pop),
    .dout_o  (mid_item),
    .empty_o (mid_empty),
    .count_o ()
  );

  // Credit check: an issued access sits in the writeback stage before
  // entering the output queue, so count it against the room.
  assign space = (OSW'(out_count) + OSW'(back_valid)) < OSW'(OUT_DEPTH);

  sbsm_back #(
    .WORK_RAM_DEPTH (WORK_RAM_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_i     (cfg_wr),
    .cfg_rd_o     (cfg_rd),
    .item_valid_i (!mid_empty),
    .item_i       (mid_item),
    .space_i      (space),
    .item_pop_o   (back_pop),
    .res_valid_o  (back_valid),
    .res_o        (back_res)
  );

  // result queue; never overflows thanks to the credit check
  sbsm_fifo #(
    .DEPTH (OUT_DEPTH),
    .T     (res_t)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .din_i   (back_res),
    .full_o  (),
    .pop_i   (pop),
    .dout_o  (out_res),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign handled_o   = out_res.handled;
  assign ram_hit_o   = out_res.ram_hit;
  assign xlat_addr_o = out_res.xlat_addr;
  assign read_data_o = out_res.read_data;
  assign mirroring_o = out_res.mirroring;

  // APB: pready tied high, write on the access phase
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata[4:0];

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_PRG_COUNT: prdata = {27'd0, cfg_rd.prg_cnt};
      default:       prdata = {27'd0, cfg_rd.chr_cnt};
    endcase
  end

endmodule
